[sv/skt_pkg.sv]
// Package: shared types and constants for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int KEY_W        = 32;
   localparam int PAY_W        = 16;
   localparam int POS_W        = 6;
   localparam int TOTAL_W      = 7;
   localparam int ENTRY_W      = KEY_W + PAY_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_LOOKUP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_DUP     = 2'd1,
      STAT_MISSING = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_CHK,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_FINISH
   } state_type;

endpackage

[sv/skt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module skt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sorted_key_table_core.sv]
// Sorted key table: binary search and entry shifting over one RAM under a sequencer.
// Each command searches with p <= ceil(log2(n+1)) probes (n = stored entries), each
// a read and a compare state, then moves entries with a read and a write state each.
// One command in flight; busy is high from acceptance until the result cycle, in
// which a new command may already be taken. Results cannot be stalled.
// Synchronous reset empties the table; RAM contents are not cleared.
`timescale 1ns / 1ps
module sorted_key_table_core #(
   parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_opcode,
   input  logic signed [skt_pkg::KEY_W-1:0]  req_record_key,
   input  logic [skt_pkg::PAY_W-1:0]         req_payload_in,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [skt_pkg::PAY_W-1:0]         rsp_payload_out,
   output logic [skt_pkg::POS_W-1:0]         rsp_position,
   output logic [skt_pkg::TOTAL_W-1:0]       rsp_entry_total
);
   import skt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0]        pay_ff, pay_in;
   logic [PAY_W-1:0]        rpay_ff, rpay_in;
   logic                    found_ff, found_in;
   status_type              stat_ff, stat_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [PAY_W-1:0]        rsp_pay_ff, rsp_pay_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;

   logic                    accept;
   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid;
   logic [CNT_W-1:0]        j_dec, j_inc;
   logic [CNT_W:0]          lo_plus1, j_plus2;
   logic                    full;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
   logic signed [KEY_W-1:0] rd_key;
   logic [PAY_W-1:0]        rd_pay;

   logic [IDX_W+POS_W-1:0]   pos_ext;
   logic [CNT_W+TOTAL_W-1:0] total_ext;

   skt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept   = start && !busy;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CNT_W:1];
   assign j_dec    = j_ff - 1'b1;
   assign j_inc    = j_ff + 1'b1;
   assign lo_plus1 = {1'b0, lo_ff} + 1'b1;
   assign j_plus2  = {1'b0, j_ff} + 2'd2;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign rd_key   = $signed(ram_rdata[ENTRY_W-1:PAY_W]);
   assign rd_pay   = ram_rdata[PAY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= (state_ff == ST_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      rpay_ff       <= rpay_in;
      found_ff      <= found_in;
      stat_ff       <= stat_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      j_ff          <= j_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) state_in = ST_SRCH_CMP;
            else if (lo_ff < count_ff) state_in = ST_CHK;
            else state_in = ST_DECIDE;
         end
         ST_SRCH_CMP: state_in = ST_SRCH_RD;
         ST_CHK:      state_in = ST_DECIDE;
         ST_DECIDE: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (found_ff || full) state_in = ST_FINISH;
                  else if (count_ff > lo_ff) state_in = ST_SHIFT_RD;
                  else state_in = ST_WRITE;
               end
               OP_REMOVE: begin
                  if (!found_ff) state_in = ST_FINISH;
                  else if (lo_plus1 < {1'b0, count_ff}) state_in = ST_SHIFT_RD;
                  else state_in = ST_FINISH;
               end
               OP_UPDATE: state_in = found_ff ? ST_WRITE : ST_FINISH;
               OP_LOOKUP: state_in = ST_FINISH;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (op_ff == OP_INSERT) begin
               state_in = (j_dec > lo_ff) ? ST_SHIFT_RD : ST_WRITE;
            end else begin
               state_in = (j_plus2 < {1'b0, count_ff}) ? ST_SHIFT_RD : ST_FINISH;
            end
         end
         ST_WRITE:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      rpay_in       = rpay_ff;
      found_in      = found_ff;
      stat_in       = stat_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      j_in          = j_ff;
      count_in      = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      ram_we        = 1'b0;
      ram_waddr     = j_ff[IDX_W-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = mid[IDX_W-1:0];
      pos_ext       = '0;
      total_ext     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = opcode_type'(req_opcode);
               key_in   = req_record_key;
               pay_in   = req_payload_in;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               rpay_in  = '0;
            end
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) ram_raddr = mid[IDX_W-1:0];
            else ram_raddr = lo_ff[IDX_W-1:0];
         end
         ST_SRCH_CMP: begin
            if (rd_key < key_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         ST_CHK: begin
            found_in = (rd_key == key_ff);
            rpay_in  = rd_pay;
         end
         ST_DECIDE: begin
            stat_in = STAT_OK;
            unique case (op_ff)
               OP_INSERT: begin
                  if (found_ff) stat_in = STAT_DUP;
                  else if (full) stat_in = STAT_FULL;
                  j_in = count_ff;
               end
               default: begin
                  if (!found_ff) stat_in = STAT_MISSING;
                  j_in = lo_ff;
               end
            endcase
         end
         ST_SHIFT_RD: begin
            if (op_ff == OP_INSERT) ram_raddr = j_dec[IDX_W-1:0];
            else ram_raddr = j_inc[IDX_W-1:0];
         end
         ST_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IDX_W-1:0];
            ram_wdata = ram_rdata;
            j_in      = (op_ff == OP_INSERT) ? j_dec : j_inc;
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff[IDX_W-1:0];
            ram_wdata = {key_ff, pay_ff};
         end
         ST_FINISH: begin
            if (stat_ff == STAT_OK && op_ff == OP_INSERT) count_in = count_ff + 1'b1;
            else if (stat_ff == STAT_OK && op_ff == OP_REMOVE) count_in = count_ff - 1'b1;
            pos_ext      = {{POS_W{1'b0}}, lo_ff[IDX_W-1:0]};
            total_ext    = {{TOTAL_W{1'b0}}, count_in};
            rsp_status_in = stat_ff;
            rsp_total_in  = total_ext[TOTAL_W-1:0];
            if (stat_ff == STAT_OK) begin
               rsp_pos_in = pos_ext[POS_W-1:0];
               rsp_pay_in = (op_ff == OP_INSERT || op_ff == OP_UPDATE) ? pay_ff : rpay_ff;
            end else begin
               rsp_pos_in = '0;
               rsp_pay_in = '0;
            end
         end
         default: ;
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_pay_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_entry_total = rsp_total_ff;

endmodule

[sv/skt_checker.sv]
// Port-level checker for the sorted key table, bound to the top level.
`timescale 1ns / 1ps
module skt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [1:0]                        rsp_status,
   input logic [skt_pkg::PAY_W-1:0]         rsp_payload_out,
   input logic [skt_pkg::POS_W-1:0]         rsp_position
);
   import skt_pkg::*;

   // a taken command keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_payload_out == '0 && rsp_position == '0)
      else $error("failed command returned non-zero payload or position");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_payload_out (rsp_payload_out),
   .rsp_position    (rsp_position)
);

[sim/sorted_key_table_checker.sv]
// Checker for the sorted key table: shadow table, expected answer queue and compare.
`timescale 1ns / 1ps
module sorted_key_table_checker #(
   parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_opcode,
   input  logic signed [skt_pkg::KEY_W-1:0]  req_record_key,
   input  logic [skt_pkg::PAY_W-1:0]         req_payload_in,
   input  logic                              rsp_valid,
   input  logic [1:0]                        rsp_status,
   input  logic [skt_pkg::PAY_W-1:0]         rsp_payload_out,
   input  logic [skt_pkg::POS_W-1:0]         rsp_position,
   input  logic [skt_pkg::TOTAL_W-1:0]       rsp_entry_total,
   output int                                fail_count,
   output int                                pending,
   output int                                dup_seen,
   output int                                full_seen
);
   import skt_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [PAY_W-1:0]    payload;
      logic [POS_W-1:0]    position;
      logic [TOTAL_W-1:0]  total;
   } table_answer_type;

   logic signed [KEY_W-1:0] held_keys [CAPACITY];
   logic [PAY_W-1:0]        held_pays [CAPACITY];
   int                      table_len;
   table_answer_type        answers_q [$];

   task automatic apply_command(input opcode_type op, input logic signed [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay);
      table_answer_type ans;
      int               slot;
      bit               hit;
      int               j;
      slot = 0;
      while (slot < table_len && held_keys[slot] < key)
         slot++;
      hit = (slot < table_len) && (held_keys[slot] == key);
      ans = '0;
      ans.status = STAT_OK;
      if (op == OP_INSERT) begin
         if (hit) begin
            ans.status = STAT_DUP;
         end else if (table_len >= CAPACITY) begin
            ans.status = STAT_FULL;
         end else begin
            for (j = table_len; j > slot; j--) begin
               held_keys[j] = held_keys[j-1];
               held_pays[j] = held_pays[j-1];
            end
            held_keys[slot] = key;
            held_pays[slot] = pay;
            table_len++;
            ans.payload  = pay;
            ans.position = slot[POS_W-1:0];
         end
      end else if (!hit) begin
         ans.status = STAT_MISSING;
      end else begin
         ans.position = slot[POS_W-1:0];
         case (op)
            OP_REMOVE: begin
               ans.payload = held_pays[slot];
               for (j = slot; j + 1 < table_len; j++) begin
                  held_keys[j] = held_keys[j+1];
                  held_pays[j] = held_pays[j+1];
               end
               table_len--;
            end
            OP_UPDATE: begin
               held_pays[slot] = pay;
               ans.payload = pay;
            end
            default: begin
               ans.payload = held_pays[slot];
            end
         endcase
      end
      ans.total = table_len[TOTAL_W-1:0];
      answers_q.push_back(ans);
   endtask

   always @(posedge clock) begin
      table_answer_type want;
      table_answer_type got;
      if (reset) begin
         table_len  = 0;
         fail_count = 0;
         dup_seen   = 0;
         full_seen  = 0;
         answers_q.delete();
      end else begin
         // result first: a transfer in the result cycle belongs to the next command
         if (rsp_valid) begin
            got.status   = status_type'(rsp_status);
            got.payload  = rsp_payload_out;
            got.position = rsp_position;
            got.total    = rsp_entry_total;
            if (got.status == STAT_DUP)
               dup_seen++;
            if (got.status == STAT_FULL)
               full_seen++;
            if (answers_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result st %0d pay %h pos %0d tot %0d",
                           $time, rsp_status, rsp_payload_out, rsp_position,
                           rsp_entry_total);
               fail_count++;
            end else begin
               want = answers_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display(
                        "%0t: exp st %0d pay %h pos %0d tot %0d, got st %0d pay %h pos %0d tot %0d",
                        $time, want.status, want.payload, want.position, want.total,
                        rsp_status, rsp_payload_out, rsp_position, rsp_entry_total);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            apply_command(opcode_type'(req_opcode), req_record_key, req_payload_in);
      end
      pending = answers_q.size();
   end

endmodule

[sim/sorted_key_table_core_tb.sv]
// Testbench top for the sorted key table: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module sorted_key_table_core_tb;
   import skt_pkg::*;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam int POOL_SIZE   = 96;
   localparam int PHASE_ITEMS = 250;
   localparam int PHASES      = 8;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_opcode = OP_LOOKUP;
   logic signed [KEY_W-1:0] req_record_key = '0;
   logic [PAY_W-1:0]        req_payload_in = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic [PAY_W-1:0]        rsp_payload_out;
   logic [POS_W-1:0]        rsp_position;
   logic [TOTAL_W-1:0]      rsp_entry_total;

   int fail_count;
   int pending;
   int dup_seen;
   int full_seen;

   bit                      idle_on = 1'b1;
   int                      op_sent [4];
   logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

   always #4 clock = ~clock;

   sorted_key_table_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_record_key  (req_record_key),
      .req_payload_in  (req_payload_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_payload_out (rsp_payload_out),
      .rsp_position    (rsp_position),
      .rsp_entry_total (rsp_entry_total)
   );

   sorted_key_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_record_key  (req_record_key),
      .req_payload_in  (req_payload_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_payload_out (rsp_payload_out),
      .rsp_position    (rsp_position),
      .rsp_entry_total (rsp_entry_total),
      .fail_count      (fail_count),
      .pending         (pending),
      .dup_seen        (dup_seen),
      .full_seen       (full_seen)
   );

   // present one command and hold it until the transfer
   task automatic issue(input opcode_type op, input logic signed [KEY_W-1:0] key,
                        input logic [PAY_W-1:0] pay);
      while (idle_on && $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_record_key <= key;
      req_payload_in <= pay;
      op_sent[op]++;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   initial begin
      int               phase;
      int               n;
      int               roll;
      int               waited;
      opcode_type       op;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0] pay;

      for (n = 0; n < 4; n++)
         op_sent[n] = 0;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 0;
      key_pool[3] = -1;
      key_pool[4] = 1;
      key_pool[5] = KEY_MIN + 1;
      key_pool[6] = KEY_MAX - 1;
      for (n = 7; n < 23; n++)
         key_pool[n] = 1000 + n;
      for (n = 23; n < POOL_SIZE; n++)
         key_pool[n] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every command, duplicate and missing keys, empty table
      issue(OP_INSERT, KEY_MIN, 16'h0001);
      issue(OP_INSERT, KEY_MAX, 16'hFFFF);
      issue(OP_INSERT, 0, 16'h0000);
      issue(OP_INSERT, -1, 16'h8000);
      issue(OP_INSERT, 1, 16'h7FFF);
      issue(OP_INSERT, 0, 16'h1234);
      issue(OP_LOOKUP, KEY_MIN, 16'hAAAA);
      issue(OP_LOOKUP, KEY_MAX, 16'h5555);
      issue(OP_LOOKUP, 0, 16'h0000);
      issue(OP_UPDATE, KEY_MAX, 16'h0000);
      issue(OP_UPDATE, 5, 16'hFFFF);
      issue(OP_LOOKUP, 5, 16'h0000);
      issue(OP_REMOVE, 5, 16'h0000);
      issue(OP_REMOVE, KEY_MIN, 16'h0000);
      issue(OP_REMOVE, KEY_MAX, 16'hFFFF);
      issue(OP_REMOVE, -1, 16'h0000);
      issue(OP_LOOKUP, 1, 16'h0000);
      issue(OP_INSERT, KEY_MIN, 16'hFFFF);
      issue(OP_REMOVE, 0, 16'h0000);
      issue(OP_REMOVE, 1, 16'h0000);
      issue(OP_REMOVE, KEY_MIN, 16'h0000);
      issue(OP_LOOKUP, 0, 16'h0000);
      issue(OP_REMOVE, 0, 16'h0000);
      issue(OP_UPDATE, 0, 16'hFFFF);

      // random: fill phases favour inserts to push the table towards full, drain phases favour removes to empty it
      for (phase = 0; phase < PHASES; phase++) begin
         idle_on = (phase != 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (phase % 2 == 0)
               op = (roll < 60) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                    (roll < 85) ? OP_UPDATE : OP_LOOKUP;
            else
               op = (roll < 15) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                    (roll < 85) ? OP_UPDATE : OP_LOOKUP;
            if ($urandom_range(0, 99) < 88)
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               key = $urandom;
            roll = $urandom_range(0, 19);
            pay = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
            issue(op, key, pay);
         end
      end
      start <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (pending != 0) begin
         $display("Timed out with %0d results outstanding", pending);
         $display("FAIL sorted_key_table_core");
      end else begin
         $display("Covered %0d commands: %0d insert, %0d remove, %0d update, %0d lookup",
                  op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3],
                  op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_UPDATE],
                  op_sent[OP_LOOKUP]);
         $display("Rejections seen: %0d duplicate key, %0d table full", dup_seen, full_seen);
         if (fail_count == 0)
            $display("PASS sorted_key_table_core");
         else
            $display("FAIL sorted_key_table_core");
      end
      $finish;
   end

   initial begin
      #(15_000_000);
      $display("Simulation time limit reached");
      $display("FAIL sorted_key_table_core");
      $finish;
   end

endmodule

[sorted_key_table_core.f]
sv/skt_pkg.sv
sv/skt_ram.sv
sv/sorted_key_table_core.sv
sv/skt_checker.sv
sim/sorted_key_table_checker.sv
sim/sorted_key_table_core_tb.sv
